// ===== design/poly_acc_pkg.sv =====
`timescale 1ns / 1ps

package poly_acc_pkg;

  localparam int NLIMB  = 5;
  localparam int LIMB_W = 26;
  localparam int IDX_W  = 3;
  localparam int A_W    = LIMB_W + 1;
  localparam int R5_W   = LIMB_W + 3;
  localparam int PROD_W = A_W + R5_W;
  localparam int D_W    = 60;
  localparam int CY_W   = D_W - LIMB_W;
  localparam int H_W    = NLIMB * LIMB_W;
  localparam int OUT_W  = 136;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [A_W-1:0]    alimb_t;
  typedef logic [R5_W-1:0]   r5limb_t;
  typedef logic [D_W-1:0]    dlimb_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_CARRY = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    REG_R_LOW  = 2'd0,
    REG_R_HIGH = 2'd1
  } reg_idx_t;

endpackage

// ===== design/poly1305_block_accumulator_core.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake        | payload
// s       | in  | s_tvalid/tready  | s_tdata: block_low, block_high; s_tlast: last_block
// m       | out | m_tvalid/tready  | m_tdata: acc_part0, acc_part1, acc_part2
// cfg     | in  | cfg_we           | cfg_index, cfg_data (r low / r high)
//
// A beat runs through the accept state, 25 products through a single 27x29
// multiplier, a drain state that empties the product register, 15 single-limb carry
// steps on a rotating limb line, and a final state for the reduction.
// Reset (rst, sync) clears h, r and the output register.
// A finished result waits in m_tdata; the next beat is taken meanwhile, and
// only a second last beat stalls in its final cycle until m is free.

module poly1305_block_accumulator_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [127:0]              s_tdata,   // block_low, block_high
  input  logic                      s_tlast,   // last_block
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [poly_acc_pkg::OUT_W-1:0] m_tdata, // acc_part0, acc_part1, acc_part2, zero pad
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [63:0]               cfg_data
);
  import poly_acc_pkg::*;

  state_t            state;
  logic [63:0]       key_r_low;
  logic [59:0]       key_r_high;
  alimb_t            a    [NLIMB];
  limb_t             rl   [NLIMB];
  r5limb_t           r5l  [NLIMB];
  dlimb_t            d    [NLIMB];
  limb_t             blimb[NLIMB];
  limb_t             klimb[NLIMB];
  logic [IDX_W-1:0]  i_cnt, j_cnt, k_idx;
  logic [PROD_W-1:0] prod;
  logic              p_vld, p_first, p_last;
  logic [IDX_W-1:0]  p_i;
  dlimb_t            mac, mac_sum;
  r5limb_t           r_sel;
  logic [IDX_W-1:0]  c_cnt;
  logic [1:0]        pass_cnt;
  logic              last_q;
  logic [CY_W-1:0]   carry;
  dlimb_t            carry_add;
  logic [H_W-1:0]    h;
  logic [H_W:0]      h_plus;
  logic [H_W-1:0]    h_red;
  logic              out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    blimb[0] = s_tdata[25:0];
    blimb[1] = s_tdata[51:26];
    blimb[2] = {s_tdata[77:64], s_tdata[63:52]};
    blimb[3] = s_tdata[103:78];
    blimb[4] = {2'b01, s_tdata[127:104]};
    klimb[0] = key_r_low[25:0];
    klimb[1] = key_r_low[51:26];
    klimb[2] = {key_r_high[13:0], key_r_low[63:52]};
    klimb[3] = key_r_high[39:14];
    klimb[4] = {6'b0, key_r_high[59:40]};
  end

  // wrap-around terms use 5*r
  always_comb begin
    if (i_cnt >= j_cnt) begin
      k_idx = i_cnt - j_cnt;
      r_sel = R5_W'(rl[k_idx]);
    end else begin
      k_idx = i_cnt + IDX_W'(NLIMB) - j_cnt;
      r_sel = r5l[k_idx];
    end
  end

  assign mac_sum = (p_first ? '0 : mac) + D_W'(prod);

  always_comb begin
    carry = d[0][D_W-1:LIMB_W];
    if (c_cnt == IDX_W'(NLIMB - 1)) begin
      carry_add = D_W'({carry, 2'b00}) + D_W'(carry);
    end else begin
      carry_add = D_W'(carry);
    end
  end

  always_comb begin
    h = {d[4][LIMB_W-1:0], d[3][LIMB_W-1:0], d[2][LIMB_W-1:0],
         d[1][LIMB_W-1:0], d[0][LIMB_W-1:0]};
    h_plus = {1'b0, h} + (H_W+1)'(5);
    h_red  = h_plus[H_W] ? h_plus[H_W-1:0] : h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_r_low  <= '0;
      key_r_high <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_R_LOW:  key_r_low  <= cfg_data;
        REG_R_HIGH: key_r_high <= cfg_data[59:0];
        default:    key_r_low  <= key_r_low;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod    <= PROD_W'(a[j_cnt]) * PROD_W'(r_sel);
    p_first <= (j_cnt == '0);
    p_last  <= (j_cnt == IDX_W'(NLIMB - 1));
    p_i     <= i_cnt;
    if (p_vld) begin
      mac <= mac_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p_vld    <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      i_cnt    <= '0;
      j_cnt    <= '0;
      c_cnt    <= '0;
      pass_cnt <= '0;
      last_q   <= 1'b0;
      for (int n = 0; n < NLIMB; n++) begin
        d[n] <= '0;
      end
    end else begin
      p_vld <= (state == S_MUL);
      if (m_tvalid && m_tready && !(state == S_FIN && last_q)) begin
        m_tvalid <= 1'b0;
      end
      if (p_vld && p_last) begin
        d[p_i] <= mac_sum;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int n = 0; n < NLIMB; n++) begin
              a[n]   <= A_W'(blimb[n]) + A_W'(d[n][LIMB_W-1:0]);
              rl[n]  <= klimb[n];
              r5l[n] <= R5_W'({klimb[n], 2'b00}) + R5_W'(klimb[n]);
            end
            last_q <= s_tlast;
            i_cnt  <= '0;
            j_cnt  <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (j_cnt == IDX_W'(NLIMB - 1)) begin
            j_cnt <= '0;
            if (i_cnt == IDX_W'(NLIMB - 1)) begin
              state <= S_DRAIN;
            end else begin
              i_cnt <= i_cnt + 1'b1;
            end
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          c_cnt    <= '0;
          pass_cnt <= '0;
          state    <= S_CARRY;
        end
        S_CARRY: begin
          // rotate: head carries into its neighbor, masked head goes to the tail
          d[0] <= d[1] + carry_add;
          for (int n = 1; n < NLIMB - 1; n++) begin
            d[n] <= d[n+1];
          end
          d[NLIMB-1] <= D_W'(d[0][LIMB_W-1:0]);
          if (c_cnt == IDX_W'(NLIMB - 1)) begin
            c_cnt    <= '0;
            pass_cnt <= pass_cnt + 1'b1;
            if (pass_cnt == 2'd2) begin
              state <= S_FIN;
            end
          end else begin
            c_cnt <= c_cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_tdata  <= OUT_W'(h_red);
            m_tvalid <= 1'b1;
            for (int n = 0; n < NLIMB; n++) begin
              d[n] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_norm: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (d[0][D_W-1:LIMB_W] == '0) && (d[1][D_W-1:LIMB_W] == '0) &&
      (d[2][D_W-1:LIMB_W] == '0) && (d[3][D_W-1:LIMB_W] == '0) &&
      (d[4][D_W-1:LIMB_W] == '0))
    else $error("accumulator limb not normalized while idle");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FIN) && $past(last_q))
    else $error("result raised outside final step");

  a_mul_feeds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> p_vld)
    else $error("product register not loaded during multiply");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && $past(state == S_IDLE) |-> !p_vld)
    else $error("product pending while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid) && !$past(m_tready) |-> m_tvalid && $stable(m_tdata))
    else $error("pending result overwritten");

endmodule
